@@ rtl/dsub_pkg.sv @@
// Shared types, constants and calendar functions for the date subtractor.
// No dependencies; imported by the top level, dsub_ctrl and dsub_datapath.
package dsub_pkg;

  // Unit selector codes
  localparam logic [2:0] UNIT_DAYS       = 3'd0;
  localparam logic [2:0] UNIT_WEEKS      = 3'd1;
  localparam logic [2:0] UNIT_MONTHS     = 3'd2;
  localparam logic [2:0] UNIT_YEARS      = 3'd3;
  localparam logic [2:0] UNIT_DECADES    = 3'd4;
  localparam logic [2:0] UNIT_CENTURIES  = 3'd5;
  localparam logic [2:0] UNIT_MILLENNIA  = 3'd6;

  // Calendar constants
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] LEN_LONG  = 5'd31;
  localparam logic [4:0] LEN_SHORT = 5'd30;
  localparam logic [4:0] LEN_FEB_LEAP   = 5'd29;
  localparam logic [4:0] LEN_FEB_COMMON = 5'd28;
  localparam int unsigned DAYS_PER_WEEK = 7;

  // Divisibility by 25 through the inverse of 25 modulo 2^16
  localparam logic [15:0] INV25    = 16'd23593;
  localparam logic [15:0] DIV25_MAX = 16'd2621;

  // Widths
  localparam int unsigned REM_W  = 18;  // up to 32767 weeks in days
  localparam int unsigned PROD_W = 25;  // amount times 1000

  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM, ST_DAYS, ST_MONTHS, ST_YEARS, ST_CLAMP, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_NORM, OP_DAY, OP_MONTH, OP_YEAR, OP_EMIT
  } op_t;

  typedef struct packed {
    logic [2:0] unit;
    logic       rem_zero;
    logic       out_busy;
  } dp_status_t;

  // Proleptic leap rule on a signed 16-bit year
  function automatic logic is_leap(input logic signed [15:0] y);
    logic [15:0] mag;
    logic [15:0] scaled;
    logic        div4;
    logic        div16;
    logic        div25;
    mag    = y[15] ? (~y + 16'd1) : y;
    scaled = mag * INV25;
    div25  = (scaled <= DIV25_MAX);
    div4   = (y[1:0] == 2'd0);
    div16  = (y[3:0] == 4'd0);
    return div4 && (!div25 || div16);
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    len = LEN_LONG;
    if (m == MONTH_FEB) begin
      len = leap ? LEN_FEB_LEAP : LEN_FEB_COMMON;
    end else if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
      len = LEN_SHORT;
    end
    return len;
  endfunction

endpackage

@@ rtl/gregorian_date_subtractor.sv @@
// Top level of the Gregorian date subtractor.
// Depends on dsub_pkg, dsub_ctrl and dsub_datapath.
//
//   channel | dir | handshake          | payload
//   s_*     | in  | s_tvalid/s_tready  | s_tuser: cmd; s_tdata: amount, year, month, day
//   m_*     | out | m_tvalid/m_tready  | m_tdata: year, month, day
//
// Per item: load and normalise, then for days and weeks one day-loop step per month
//   borrowed and one more for a partial month, for months one step per month, for year
//   units a year step and a clamp; an unknown unit goes straight to the result.
// One item in flight; s_tready is high only while the controller is idle.
// The result waits in the output register under m_tready stalls while the next
// item is accepted. Synchronous active-high reset clears control state only.
module gregorian_date_subtractor
  import dsub_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // amount[14:0], in_year[30:15], in_month[34:31], in_day[39:35]
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // out_year[15:0], out_month[19:16], out_day[24:20], zeros
);

  op_t                op;
  dp_status_t         status;
  logic signed [15:0] out_year;
  logic [3:0]         out_month;
  logic [4:0]         out_day;

  dsub_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .op       (op)
  );

  dsub_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .cmd       (s_tuser),
    .amount    (s_tdata[14:0]),
    .in_year   ($signed(s_tdata[30:15])),
    .in_month  (s_tdata[34:31]),
    .in_day    (s_tdata[39:35]),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_year  (out_year),
    .out_month (out_month),
    .out_day   (out_day)
  );

  assign m_tdata = {7'd0, out_day, out_month, out_year};

endmodule

@@ rtl/dsub_ctrl.sv @@
// Controller state machine of the date subtractor.
// Depends on dsub_pkg; drives dsub_datapath through op_t commands.
module dsub_ctrl
  import dsub_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output op_t        op
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_NORM;
      end
      ST_NORM: begin
        case (status.unit)
          UNIT_DAYS, UNIT_WEEKS: state_next = ST_DAYS;
          UNIT_MONTHS:           state_next = ST_MONTHS;
          UNIT_YEARS, UNIT_DECADES, UNIT_CENTURIES, UNIT_MILLENNIA:
                                 state_next = ST_YEARS;
          default:               state_next = ST_DONE;
        endcase
      end
      ST_DAYS, ST_MONTHS: begin
        if (status.rem_zero) state_next = ST_DONE;
      end
      ST_YEARS: state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_DONE;
      ST_DONE: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LOAD;
      end
      ST_NORM, ST_CLAMP: op = OP_NORM;
      ST_DAYS: begin
        if (!status.rem_zero) op = OP_DAY;
      end
      ST_MONTHS: begin
        if (!status.rem_zero) op = OP_MONTH;
      end
      ST_YEARS: op = OP_YEAR;
      ST_DONE: begin
        if (!status.out_busy) op = OP_EMIT;
      end
      default: op = OP_NONE;
    endcase
  end

endmodule

@@ rtl/dsub_datapath.sv @@
// Datapath of the date subtractor: date registers, countdown, scaled year
// product and the output register. Depends on dsub_pkg; driven by dsub_ctrl.
module dsub_datapath
  import dsub_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  op_t                op,
  input  logic [2:0]         cmd,
  input  logic [14:0]        amount,
  input  logic signed [15:0] in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day,
  output dp_status_t         status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day
);

  logic signed [15:0] year;
  logic [3:0]         month;
  logic [4:0]         day;
  logic [2:0]         unit;
  logic [REM_W-1:0]   rem;
  logic [PROD_W-1:0]  prod;

  logic               leap;
  logic [3:0]         month_fix;
  logic [4:0]         day_min;
  logic [4:0]         len_fix;
  logic [3:0]         month_prev;
  logic signed [15:0] year_prev;
  logic [4:0]         len_prev;
  logic [9:0]         scale;
  logic [REM_W-1:0]   day_ext;

  // Leap flag always from the registered year
  assign leap = is_leap(year);

  // Range correction of month and day (also the clamp after a year change)
  always_comb begin
    month_fix = month;
    if (month == 4'd0) month_fix = MONTH_JAN;
    else if (month > MONTH_DEC) month_fix = MONTH_DEC;
    day_min = (day == 5'd0) ? 5'd1 : day;
    len_fix = month_len(leap, month_fix);
  end

  // One month back; February keeps the year, so the registered leap flag holds
  always_comb begin
    if (month == MONTH_JAN) begin
      month_prev = MONTH_DEC;
      year_prev  = year - 16'sd1;
    end else begin
      month_prev = month - 4'd1;
      year_prev  = year;
    end
    len_prev = month_len(leap, month_prev);
  end

  // Year multiplier per unit
  always_comb begin
    case (cmd)
      UNIT_DECADES:   scale = 10'd10;
      UNIT_CENTURIES: scale = 10'd100;
      UNIT_MILLENNIA: scale = 10'd1000;
      default:        scale = 10'd1;
    endcase
  end

  assign day_ext = {{(REM_W-5){1'b0}}, day};

  // Working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        year  <= in_year;
        month <= in_month;
        day   <= in_day;
        unit  <= cmd;
        rem   <= (cmd == UNIT_WEEKS) ? REM_W'(amount) * REM_W'(DAYS_PER_WEEK)
                                     : REM_W'(amount);
        prod  <= PROD_W'(amount) * PROD_W'(scale);
      end
      OP_NORM: begin
        month <= month_fix;
        day   <= (day_min > len_fix) ? len_fix : day_min;
      end
      OP_DAY: begin
        if (rem < day_ext) begin
          day <= day - rem[4:0];
          rem <= '0;
        end else begin
          rem   <= rem - day_ext;
          month <= month_prev;
          year  <= year_prev;
          day   <= len_prev;
        end
      end
      OP_MONTH: begin
        rem   <= rem - REM_W'(1);
        month <= month_prev;
        year  <= year_prev;
        if (day > len_prev) day <= len_prev;
      end
      OP_YEAR: begin
        year <= year - $signed(prod[15:0]);
      end
      default: ;
    endcase
  end

  // Output register, loaded only when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      out_year  <= year;
      out_month <= month;
      out_day   <= day;
    end
  end

  assign status.unit     = unit;
  assign status.rem_zero = (rem == '0);
  assign status.out_busy = out_valid && !out_ready;

endmodule

@@ rtl/dsub_checker.sv @@
// Port-level checks for the date subtractor, bound to the top level.
// Depends only on the top level's ports.
module dsub_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");

  // One item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  // Result is a valid month and a nonzero day
  a_valid_date: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[19:16] != 4'd0 && m_tdata[19:16] <= 4'd12
                 && m_tdata[24:20] != 5'd0)
    else $error("result date out of range");

  // February never exceeds 29 days; short months never reach 31
  a_month_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[19:16] == 4'd2 && m_tdata[24:20] > 5'd29)
                 && !((m_tdata[19:16] == 4'd4 || m_tdata[19:16] == 4'd6
                       || m_tdata[19:16] == 4'd9 || m_tdata[19:16] == 4'd11)
                      && m_tdata[24:20] == 5'd31))
    else $error("result day beyond month length");

endmodule

bind gregorian_date_subtractor dsub_checker u_dsub_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ sim/gregorian_date_subtractor_tb.sv @@
// Self-checking testbench for gregorian_date_subtractor: directed calendar corners, then
// random requests under random idling on both streams. Depends on dsub_pkg and the RTL top.
module gregorian_date_subtractor_tb
  import dsub_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // cmd value the block has no unit for
  localparam logic [2:0] UNIT_UNKNOWN = 3'd7;

  typedef struct packed {
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
  } cal_date_t;

  // Expected dates in arrival order, with its own calendar arithmetic
  class back_date_scoreboard;
    cal_date_t   pending_dates[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int wrap_year(int y);
      return int'(shortint'(y));
    endfunction

    function bit leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int month_days(int y, int m);
      if (m == MONTH_FEB) begin
        return leap_year(y) ? 29 : 28;
      end
      if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
        return 30;
      end
      return 31;
    endfunction

    function void back_one_month(inout int y, inout int m);
      if (m == MONTH_JAN) begin
        m = MONTH_DEC;
        y = wrap_year(y - 1);
      end else begin
        m = m - 1;
      end
    endfunction

    // Date moved back by amount units, after correcting the start date
    function cal_date_t back_date(logic [2:0] unit, logic [14:0] amount,
                                  logic signed [15:0] year, logic [3:0] month,
                                  logic [4:0] day);
      int          y;
      int          m;
      int          d;
      int          len;
      int          k;
      int          mi;
      int unsigned rem;
      cal_date_t   r;
      y = year;
      m = month;
      d = day;
      if (m < MONTH_JAN) m = MONTH_JAN;
      if (m > MONTH_DEC) m = MONTH_DEC;
      if (d < 1) d = 1;
      len = month_days(y, m);
      if (d > len) d = len;
      case (unit)
        UNIT_DAYS, UNIT_WEEKS: begin
          rem = (unit == UNIT_WEEKS) ? int'(amount) * DAYS_PER_WEEK : int'(amount);
          // borrow a whole month at a time
          while (rem > 0) begin
            if (rem < d) begin
              d = d - int'(rem);
              rem = 0;
            end else begin
              rem = rem - d;
              back_one_month(y, m);
              d = month_days(y, m);
            end
          end
        end
        UNIT_MONTHS: begin
          rem = amount;
          // a day above 28 can still be clamped: step singly
          while (rem > 0 && d > 28) begin
            back_one_month(y, m);
            len = month_days(y, m);
            if (d > len) d = len;
            rem--;
          end
          y  = wrap_year(y - int'(rem / 12));
          mi = (m - 1) - int'(rem % 12);
          if (mi < 0) begin
            mi = mi + 12;
            y  = wrap_year(y - 1);
          end
          m = mi + 1;
        end
        UNIT_YEARS, UNIT_DECADES, UNIT_CENTURIES, UNIT_MILLENNIA: begin
          case (unit)
            UNIT_YEARS:     k = 1;
            UNIT_DECADES:   k = 10;
            UNIT_CENTURIES: k = 100;
            default:        k = 1000;
          endcase
          y   = wrap_year(y - int'(amount) * k);
          len = month_days(y, m);
          if (d > len) d = len;
        end
        default: ;
      endcase
      r.year  = y[15:0];
      r.month = m[3:0];
      r.day   = d[4:0];
      return r;
    endfunction

    function void note_request(logic [2:0] unit, logic [14:0] amount,
                               logic signed [15:0] year, logic [3:0] month,
                               logic [4:0] day);
      pending_dates.push_back(back_date(unit, amount, year, month, day));
    endfunction

    function void check_date(logic [31:0] tdata);
      cal_date_t want;
      cal_date_t got;
      got.year  = tdata[15:0];
      got.month = tdata[19:16];
      got.day   = tdata[24:20];
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result %0d-%0d-%0d", got.year, got.month, got.day);
        end
        return;
      end
      want = pending_dates.pop_front();
      if (got.year != want.year || got.month != want.month || got.day != want.day) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("date mismatch: expected %0d-%0d-%0d, got %0d-%0d-%0d",
                   want.year, want.month, want.day, got.year, got.month, got.day);
        end
      end
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // amount[14:0], in_year[30:15], in_month[34:31], in_day[39:35]
  logic [2:0]  s_tuser = '0;   // cmd[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // out_year[15:0], out_month[19:16], out_day[24:20], zeros

  logic        no_idle = 1'b0;
  logic        hold_off = 1'b0;
  int unsigned accepted = 0;

  back_date_scoreboard sb = new();

  gregorian_date_subtractor i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: random stalls, none in the quiet window, fully off while held
  always @(posedge clk) begin
    if (rst || hold_off) begin
      m_tready <= 1'b0;
    end else if (no_idle) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 24);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_date(m_tdata);
    end
  end

  // Long output stall once the random part is under way; the input backs up
  initial begin
    wait (accepted >= 70);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_request(logic [2:0] unit, logic [14:0] amount,
                              logic signed [15:0] year, logic [3:0] month,
                              logic [4:0] day);
    while (!no_idle && $urandom_range(0, 99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= unit;
    s_tdata  <= {day, month, year, amount};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(unit, amount, year, month, day);
    accepted++;
  endtask

  // One random request, mostly well-formed, biased to leap and century corners
  task automatic send_random_request();
    logic [2:0]         unit;
    logic [14:0]        amount;
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    int                 pick;
    unit = ($urandom_range(0, 15) == 0) ? UNIT_UNKNOWN : 3'($urandom_range(0, 6));
    pick = $urandom_range(0, 9);
    if (pick < 6) amount = 15'($urandom_range(0, 40));
    else if (pick < 9) amount = 15'($urandom_range(0, 1000));
    else amount = 15'($urandom_range(0, 32767));
    // each month is a separate step: keep them short here
    if (unit == UNIT_MONTHS && amount > 1200) amount = 15'($urandom_range(0, 1200));
    case ($urandom_range(0, 3))
      0: year = 16'($urandom_range(0, 65535));
      1: year = 16'(int'($urandom_range(0, 655)) * 100 - 32768 + int'($urandom_range(0, 4)));
      2: year = 16'($urandom_range(1900, 2100));
      default: year = 16'(int'($urandom_range(0, 20)) - 10);
    endcase
    month = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(1, 12));
    day   = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(1, 31));
    if ($urandom_range(0, 7) == 0) begin
      month = MONTH_FEB;
      day   = 5'd29;
    end
    send_request(unit, amount, year, month, day);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: leap borrows, clamps, wraps, odd start dates
    send_request(UNIT_DAYS,      15'd1,     16'sd2024,   4'd3,  5'd1);
    send_request(UNIT_DAYS,      15'd1,     16'sd2023,   4'd3,  5'd1);
    send_request(UNIT_DAYS,      15'd1,     16'sd1,      4'd1,  5'd1);
    send_request(UNIT_DAYS,      15'd0,     16'sd1999,   4'd7,  5'd15);
    send_request(UNIT_DAYS,      15'd32767, 16'sd32767,  4'd12, 5'd31);
    send_request(UNIT_WEEKS,     15'd32767, -16'sd32768, 4'd1,  5'd1);
    send_request(UNIT_WEEKS,     15'd1,     16'sd2000,   4'd3,  5'd3);
    send_request(UNIT_MONTHS,    15'd1,     16'sd2023,   4'd3,  5'd31);
    send_request(UNIT_MONTHS,    15'd2,     16'sd2023,   4'd3,  5'd31);
    send_request(UNIT_MONTHS,    15'd13,    16'sd1,      4'd1,  5'd15);
    send_request(UNIT_MONTHS,    15'd32767, 16'sd2000,   4'd12, 5'd31);
    send_request(UNIT_YEARS,     15'd1,     16'sd2024,   4'd2,  5'd29);
    send_request(UNIT_YEARS,     15'd4,     16'sd2000,   4'd2,  5'd29);
    send_request(UNIT_YEARS,     15'd0,     16'sd2019,   4'd6,  5'd30);
    send_request(UNIT_DECADES,   15'd1,     16'sd2010,   4'd2,  5'd29);
    send_request(UNIT_CENTURIES, 15'd1,     16'sd2000,   4'd2,  5'd29);
    send_request(UNIT_CENTURIES, 15'd4,     -16'sd400,   4'd2,  5'd29);
    send_request(UNIT_MILLENNIA, 15'd32767, 16'sd0,      4'd2,  5'd29);
    send_request(UNIT_UNKNOWN,   15'd12345, 16'sd2021,   4'd0,  5'd0);
    send_request(UNIT_DAYS,      15'd3,     16'sd2021,   4'd15, 5'd31);
    send_request(UNIT_YEARS,     15'd1,     16'sd2021,   4'd13, 5'd31);
    send_request(UNIT_DAYS,      15'd1,     16'sd2021,   4'd4,  5'd31);
    send_request(UNIT_MONTHS,    15'd1,     16'sd2024,   4'd2,  5'd30);
    send_request(UNIT_YEARS,     15'd1,     -16'sd32768, 4'd3,  5'd0);

    // Random part, with a quiet stretch where neither side idles
    for (int n = 0; n < 76; n++) begin
      if (n == 30) no_idle <= 1'b1;
      if (n == 55) no_idle <= 1'b0;
      send_random_request();
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("gregorian_date_subtractor verification clean");
    end else begin
      $display("gregorian_date_subtractor verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #32_000_000;
    $display("gregorian_date_subtractor verification failed");
    $finish;
  end

endmodule

@@ gregorian_date_subtractor.f @@
rtl/dsub_pkg.sv
rtl/dsub_ctrl.sv
rtl/dsub_datapath.sv
rtl/gregorian_date_subtractor.sv
rtl/dsub_checker.sv
sim/gregorian_date_subtractor_tb.sv
